FILE: rtl/h264_rtp_fua_packetizer_assert.svh
`ifndef H264_RTP_FUA_PACKETIZER_ASSERT_SVH
`define H264_RTP_FUA_PACKETIZER_ASSERT_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/rtpfua_pkg.sv
package rtpfua_pkg;

   localparam int LENGTH_BITS_DEFAULT = 20;
   localparam int QUEUE_DEPTH         = 4;
   localparam int HDR_BYTES           = 12;

   localparam logic [16:0] RESET_TIMESTAMP_STEP = 17'd3600;
   localparam logic [10:0] RESET_MAX_PAYLOAD    = 11'd1400;
   localparam logic [6:0]  RESET_RTP_PT         = 7'd96;
   localparam logic [31:0] RESET_SSRC           = 32'd0;

   localparam logic [10:0] MIN_PAYLOAD   = 11'd2;
   localparam logic [7:0]  RTP_VER_BYTE  = 8'h80;
   localparam logic [7:0]  FU_A_TYPE     = 8'd28;
   localparam logic [7:0]  NRI_MASK      = 8'he0;
   localparam logic [7:0]  TYPE_MASK     = 8'h1f;
   localparam logic [7:0]  FU_START_BIT  = 8'h80;
   localparam logic [7:0]  FU_END_BIT    = 8'h40;

   localparam logic [3:0]  POS_FU_IND    = 4'd12;
   localparam logic [3:0]  POS_FU_HDR    = 4'd13;
   localparam logic [3:0]  POS_DATA      = 4'd14;

   typedef enum logic [1:0] {
      CSR_TIMESTAMP_STEP = 2'd0,
      CSR_MAX_PAYLOAD    = 2'd1,
      CSR_RTP_PT         = 2'd2,
      CSR_SSRC           = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [16:0] timestamp_step;
      logic [10:0] eff_payload;
      logic [6:0]  rtp_pt;
      logic [31:0] ssrc;
   } cfg_type;

   typedef struct packed {
      logic        hdr;
      logic        marker;
      logic [15:0] seq;
      logic [31:0] ts;
      logic        fu;
      logic [7:0]  fu_ind;
      logic [7:0]  fu_hdr;
      logic        has_byte;
      logic [7:0]  data;
      logic        last;
   } cmd_type;

endpackage

FILE: rtl/h264_rtp_fua_packetizer.sv
// H.264 RTP packetizer with FU-A fragmentation. Each accepted NAL byte is
// turned into a command by the front end and queued (four entries); the back
// end plays commands out one RTP byte per cycle unless rsp_stall is high. An
// item that opens a packet emits the RTP header and its data byte (single-
// packet start), the header, FU indicator and FU header (first fragment), or
// the header, FU indicator, FU header and data byte (later fragment), and the
// input stalls while the queue is full behind it. Sustained throughput is set
// by the output port. Configuration writes are always accepted (csr_ready is
// tied high) and must be made while no packet data is pending.
module h264_rtp_fua_packetizer
   import rtpfua_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_nal_byte,
   input  logic                   req_nal_start,
   input  logic [LENGTH_BITS-1:0] req_nal_length,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_packet_end,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [31:0]            csr_data
);

   logic [16:0] ts_step_ff;
   logic [10:0] max_payload_ff;
   logic [6:0]  rtp_pt_ff;
   logic [31:0] ssrc_ff;
   cfg_type     cfg;
   logic        q_full;
   logic        q_empty;
   logic        push;
   logic        pop;
   cmd_type     push_cmd;
   cmd_type     head;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg.timestamp_step = ts_step_ff;
      cfg.eff_payload    = (max_payload_ff < MIN_PAYLOAD) ? MIN_PAYLOAD : max_payload_ff;
      cfg.rtp_pt         = rtp_pt_ff;
      cfg.ssrc           = ssrc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ts_step_ff      <= RESET_TIMESTAMP_STEP;
         max_payload_ff  <= RESET_MAX_PAYLOAD;
         rtp_pt_ff       <= RESET_RTP_PT;
         ssrc_ff         <= RESET_SSRC;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_TIMESTAMP_STEP: ts_step_ff      <= csr_data[16:0];
            CSR_MAX_PAYLOAD:    max_payload_ff  <= csr_data[10:0];
            CSR_RTP_PT:         rtp_pt_ff       <= csr_data[6:0];
            CSR_SSRC:           ssrc_ff         <= csr_data;
            default: begin
            end
         endcase
      end
   end

   rtpfua_front #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_nal_byte   (req_nal_byte),
      .req_nal_start  (req_nal_start),
      .req_nal_length (req_nal_length),
      .q_full         (q_full),
      .push           (push),
      .cmd            (push_cmd)
   );

   rtpfua_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .full     (q_full),
      .empty    (q_empty)
   );

   rtpfua_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .head           (head),
      .empty          (q_empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_packet_end (rsp_packet_end)
   );

endmodule

FILE: rtl/rtpfua_front.sv
module rtpfua_front
   import rtpfua_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_nal_byte,
   input  logic                   req_nal_start,
   input  logic [LENGTH_BITS-1:0] req_nal_length,
   input  logic                   q_full,
   output logic                   push,
   output cmd_type                cmd
);

   logic [15:0]            seq_ff, seq_in;
   logic [31:0]            ts_ff, ts_in;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;
   logic [10:0]            fill_ff, fill_in, fill_base;
   logic [7:0]             saved_ff, saved_in;
   logic                   frag_ff, frag_in;
   logic                   accept;
   logic [LENGTH_BITS-1:0] eff_ext;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign eff_ext   = LENGTH_BITS'(cfg.eff_payload);

   always_comb begin
      seq_in    = seq_ff;
      ts_in     = ts_ff;
      rem_in    = rem_ff;
      fill_in   = fill_ff;
      saved_in  = saved_ff;
      frag_in   = frag_ff;
      fill_base = fill_ff;
      push      = 1'b0;
      cmd       = '0;
      if (accept) begin
         if (req_nal_start) begin
            ts_in   = ts_ff + 32'(cfg.timestamp_step);
            frag_in = 1'b0;
            fill_in = '0;
            rem_in  = '0;
            if (req_nal_length != '0) begin
               rem_in  = req_nal_length - LENGTH_BITS'(1);
               seq_in  = seq_ff + 16'd1;
               push    = 1'b1;
               cmd.hdr = 1'b1;
               if (req_nal_length <= eff_ext) begin
                  cmd.has_byte = 1'b1;
                  cmd.data     = req_nal_byte;
                  cmd.last     = (rem_in == '0);
               end else begin
                  saved_in   = req_nal_byte;
                  frag_in    = 1'b1;
                  fill_in    = 11'd1;
                  cmd.fu     = 1'b1;
                  cmd.fu_ind = (req_nal_byte & NRI_MASK) | FU_A_TYPE;
                  cmd.fu_hdr = FU_START_BIT | (req_nal_byte & TYPE_MASK);
               end
            end
         end else if (rem_ff != '0) begin
            push         = 1'b1;
            cmd.has_byte = 1'b1;
            cmd.data     = req_nal_byte;
            rem_in       = rem_ff - LENGTH_BITS'(1);
            if (!frag_ff) begin
               cmd.last = (rem_in == '0);
            end else begin
               if (fill_ff >= cfg.eff_payload) begin
                  seq_in     = seq_ff + 16'd1;
                  cmd.hdr    = 1'b1;
                  cmd.marker = (rem_ff <= eff_ext);
                  cmd.fu     = 1'b1;
                  cmd.fu_ind = (saved_ff & NRI_MASK) | FU_A_TYPE;
                  cmd.fu_hdr = (cmd.marker ? FU_END_BIT : 8'h00) | (saved_ff & TYPE_MASK);
                  fill_base  = '0;
               end
               fill_in  = fill_base + 11'd1;
               cmd.last = (rem_in == '0) || (fill_in >= cfg.eff_payload);
            end
         end
      end
      cmd.seq = seq_in;
      cmd.ts  = ts_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff   <= '0;
         ts_ff    <= '0;
         rem_ff   <= '0;
         fill_ff  <= '0;
         saved_ff <= '0;
         frag_ff  <= 1'b0;
      end else begin
         seq_ff   <= seq_in;
         ts_ff    <= ts_in;
         rem_ff   <= rem_in;
         fill_ff  <= fill_in;
         saved_ff <= saved_in;
         frag_ff  <= frag_in;
      end
   end

endmodule

FILE: rtl/rtpfua_queue.sv
`include "h264_rtp_fua_packetizer_assert.svh"

module rtpfua_queue
   import rtpfua_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head,
   output logic    full,
   output logic    empty
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

   cmd_type               mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]     count_ff, count_in;

   assign full  = (count_ff == (PTR_BITS + 1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + (PTR_BITS + 1)'(push) - (PTR_BITS + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `ASSERT_IMPLIES(a_no_push_full, clock, reset, push, !full)
   `ASSERT_IMPLIES(a_no_pop_empty, clock, reset, pop, !empty)
   `ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= (PTR_BITS + 1)'(QUEUE_DEPTH))
   `ASSERT_NEXT(a_push_lands, clock, reset, push && !pop, !empty)

endmodule

FILE: rtl/rtpfua_back.sv
module rtpfua_back
   import rtpfua_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  cmd_type    head,
   input  logic       empty,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_packet_end
);

   logic [3:0] pos_ff, pos_in;
   logic [3:0] cur_pos;
   logic       xfer;
   logic       at_last;
   logic [7:0] hdr_bytes [HDR_BYTES];

   assign rsp_valid = !empty;
   assign xfer      = rsp_valid && !rsp_stall;

   always_comb begin
      hdr_bytes[0]  = RTP_VER_BYTE;
      hdr_bytes[1]  = {head.marker, cfg.rtp_pt};
      hdr_bytes[2]  = head.seq[15:8];
      hdr_bytes[3]  = head.seq[7:0];
      hdr_bytes[4]  = head.ts[31:24];
      hdr_bytes[5]  = head.ts[23:16];
      hdr_bytes[6]  = head.ts[15:8];
      hdr_bytes[7]  = head.ts[7:0];
      hdr_bytes[8]  = cfg.ssrc[31:24];
      hdr_bytes[9]  = cfg.ssrc[23:16];
      hdr_bytes[10] = cfg.ssrc[15:8];
      hdr_bytes[11] = cfg.ssrc[7:0];
   end

   always_comb begin
      if (!head.hdr || (!head.fu && pos_ff >= POS_FU_IND)) begin
         cur_pos = POS_DATA;
      end else begin
         cur_pos = pos_ff;
      end
      at_last = (cur_pos == POS_DATA) || (cur_pos == POS_FU_HDR && !head.has_byte);
      pop     = xfer && at_last;
      if (!xfer) begin
         pos_in = pos_ff;
      end else if (at_last) begin
         pos_in = '0;
      end else begin
         pos_in = cur_pos + 4'd1;
      end
      rsp_packet_end = 1'b0;
      if (cur_pos < POS_FU_IND) begin
         rsp_out_byte = hdr_bytes[cur_pos];
      end else if (cur_pos == POS_FU_IND) begin
         rsp_out_byte = head.fu_ind;
      end else if (cur_pos == POS_FU_HDR) begin
         rsp_out_byte = head.fu_hdr;
      end else begin
         rsp_out_byte   = head.data;
         rsp_packet_end = head.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule
